// ===== hdl/acfp_pkg.sv =====
// Package for the additive-checksum frame parser.
// Holds the parser phase codes, result kind codes and the start mark.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfp_pkg;

  localparam logic [7:0] START_MARK = 8'h3E;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_HCHK = 3'd3,
    PH_BODY = 3'd4,
    PH_BCHK = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_HERR = 2'd2,
    KIND_BERR = 2'd3
  } kind_t;

endpackage

`default_nettype wire

// ===== hdl/additive_checksum_frame_parser_core.sv =====
// Additive-checksum serial frame parser, top level.
// Depends on acfp_pkg (phase and kind codes, start mark).
//
// Usage:
//   Input channel (in_valid / in_ready / rx_byte) carries one received byte
//   per transfer. The parser hunts for the start mark 0x3E, then takes a
//   command byte, a length byte and a header check byte (command + length
//   mod 256), then "length" payload bytes and a body check byte (8-bit sum
//   of the payload).
//   Output channel (out_valid / out_ready / kind, command_id, data_byte,
//   byte_index, frame_length) carries at most one result per input byte:
//   each payload byte (kind 0), frame accepted (1), header check error (2)
//   or body check error (3). Mark, command, length and a good header check
//   byte give no result.
//   Path: a byte is taken into an input register, then one pass of the
//   parser logic writes the result register, from which the result can
//   transfer when out_ready is high.
//   Throughput: one byte per cycle unless the result register stalls.
//   The loops are the 8-bit running sum, byte counter and phase register.
//   Stall: while the result register holds an untaken result, the input
//   register still fills; a byte that gives no result passes through even
//   then. in_ready drops only when both are full and blocked.
//   Reset (rst, synchronous): parser returns to hunting, sums and counters
//   clear, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module additive_checksum_frame_parser_core
  import acfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      command_id,
  output logic [7:0]      data_byte,
  output logic [7:0]      byte_index,
  output logic [7:0]      frame_length
);

  // Input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Parser state
  phase_t     phase, phase_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] body_length, body_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] bytes_seen, bytes_seen_next;

  // Result of the current byte
  logic       has_res;
  kind_t      res_kind;
  logic [7:0] res_data;
  logic [7:0] res_idx;

  logic       advance;
  logic       out_free;

  // Result register is free when empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;
  // A byte with no result never needs the output register.
  assign advance  = s1_valid && (out_free || !has_res);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_CMD:  phase_next = PH_LEN;
      PH_LEN:  phase_next = PH_HCHK;
      PH_HCHK: begin
        if (running_sum != s1_byte) begin
          phase_next = PH_HUNT;
        end else if (body_length == 8'd0) begin
          phase_next = PH_BCHK;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (bytes_seen + 8'd1 == body_length) begin
          phase_next = PH_BCHK;
        end
      end
      PH_BCHK: phase_next = PH_HUNT;
      default: begin
        // hunting, and any unused code
        phase_next = (s1_byte == START_MARK) ? PH_CMD : PH_HUNT;
      end
    endcase
  end

  // Datapath and result
  always_comb begin
    frame_command_next = frame_command;
    body_length_next   = body_length;
    running_sum_next   = running_sum;
    bytes_seen_next    = bytes_seen;
    has_res            = 1'b0;
    res_kind           = KIND_DATA;
    res_data           = 8'd0;
    res_idx            = 8'd0;
    unique case (phase)
      PH_CMD: begin
        frame_command_next = s1_byte;
        running_sum_next   = s1_byte;
      end
      PH_LEN: begin
        body_length_next = s1_byte;
        running_sum_next = running_sum + s1_byte;
      end
      PH_HCHK: begin
        running_sum_next = 8'd0;
        if (running_sum != s1_byte) begin
          has_res  = 1'b1;
          res_kind = KIND_HERR;
        end else begin
          bytes_seen_next = 8'd0;
        end
      end
      PH_BODY: begin
        running_sum_next = running_sum + s1_byte;
        bytes_seen_next  = bytes_seen + 8'd1;
        has_res          = 1'b1;
        res_kind         = KIND_DATA;
        res_data         = s1_byte;
        res_idx          = bytes_seen;
      end
      PH_BCHK: begin
        has_res  = 1'b1;
        res_kind = (running_sum == s1_byte) ? KIND_OK : KIND_BERR;
      end
      default: begin
        if (s1_byte == START_MARK) begin
          running_sum_next = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_command <= 8'd0;
      body_length   <= 8'd0;
      running_sum   <= 8'd0;
      bytes_seen    <= 8'd0;
    end else if (advance) begin
      phase         <= phase_next;
      frame_command <= frame_command_next;
      body_length   <= body_length_next;
      running_sum   <= running_sum_next;
      bytes_seen    <= bytes_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && has_res) begin
      kind         <= res_kind;
      command_id   <= frame_command_next;
      data_byte    <= res_data;
      byte_index   <= res_idx;
      frame_length <= body_length_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/acfp_checker.sv =====
// Port-level checker for the additive-checksum frame parser.
// Depends on acfp_pkg; bound to additive_checksum_frame_parser_core below.
`timescale 1ns / 1ps
`default_nettype none

module acfp_checker
  import acfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic [7:0] data_byte,
  input wire logic [7:0] byte_index
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("result changed while stalled");

  // Status results carry zero data and index.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && byte_index == 8'd0)
    else $error("status result with nonzero data or index");

  // Payload index never reaches 255.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> byte_index != 8'hFF)
    else $error("payload index out of range");

  // Empty pipeline after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind additive_checksum_frame_parser_core acfp_checker u_acfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .data_byte (data_byte),
  .byte_index(byte_index)
);

`default_nettype wire
